>>> hdl/tkr_pkg.sv
// Package for the top-k replace-max filter: command codes, field widths and
// the control struct passed from the sequencer to the scan unit.
// No dependencies.
package tkr_pkg;

    localparam int KEY_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int TAG_IO_W = 16;
    localparam int CMD_W    = 2;

    // Command codes; code 3 is unused and answers with an all-zero result.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_OFFER = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    // One read beat handed to the scan unit.
    typedef struct packed {
        logic valid;  // read data of the scanned entry is present this cycle
        logic first;  // entry is slot 0: restart the running maximum
    } t_scan_ctl;

endpackage

>>> hdl/top_k_replace_max_filter.sv
// Top level of the top-k replace-max filter: command sequencer, output
// register. Depends on tkr_pkg, tkr_mem and tkr_scan.
//
//  channel   dir  tdata (low bit up)                    tuser
//  s_axis    in   slot[5:0] cand_key[37:6]              command[1:0]
//                 cand_tag[53:38] pad[55:54]
//  m_axis    out  out_key[31:0] out_tag[47:32]          accepted[0]
//                 out_slot[53:48] pad[55:54]
//
// One transaction is in flight at a time. Load and unused commands go from
// start to the final state, an in-range read passes a read-wait state, and
// offer scans one entry per cycle through the single memory read port into
// one comparator, then decides and writes the candidate over the max entry.
// Reset (synchronous, active low) clears the sequencer and output valid only;
// the entry store is not cleared and must be loaded before offers or reads.
// A stalled m_axis holds the finished result in the output register and the
// sequencer waits in its final state; s_axis is ready only when idle.
module top_k_replace_max_filter #(
    parameter int ENTRIES  = 64,
    parameter int TAG_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // slot, cand_key, cand_tag, pad
    input  logic [1:0]  i_s_axis_tuser,   // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // out_key, out_tag, out_slot, pad
    output logic [0:0]  o_m_axis_tuser    // accepted
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int KW = tkr_pkg::KEY_W;
    localparam int SW = tkr_pkg::SLOT_W;
    localparam int TW = tkr_pkg::TAG_IO_W;
    localparam int MW = KW + TAG_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RDWAIT,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } t_state;

    t_state                r_state;
    tkr_pkg::t_cmd         r_cmd;
    logic [SW-1:0]         r_slot;
    logic signed [KW-1:0]  r_key;
    logic [TAG_BITS-1:0]   r_tag;
    logic [CW-1:0]         r_cnt;
    logic                  r_pend;
    logic [AW-1:0]         r_pend_idx;

    // result staged before the output register
    logic signed [KW-1:0]  r_res_key;
    logic [TAG_BITS-1:0]   r_res_tag;
    logic [SW-1:0]         r_res_slot;
    logic                  r_res_acc;

    logic                  r_m_valid;
    logic signed [KW-1:0]  r_out_key;
    logic [TW-1:0]         r_out_tag;
    logic [SW-1:0]         r_out_slot;
    logic                  r_out_acc;

    logic                  w_in_accept;
    logic                  w_out_free;
    logic                  w_in_range;
    logic [AW-1:0]         w_slot_idx;
    logic                  w_take;
    logic                  w_scan_more;
    logic                  w_scan_last;

    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [MW-1:0]         w_wr_data;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [MW-1:0]         w_rd_data;
    logic signed [KW-1:0]  w_rd_key;
    logic [TAG_BITS-1:0]   w_rd_tag;

    tkr_pkg::t_scan_ctl    w_scan_ctl;
    logic signed [KW-1:0]  w_max_key;
    logic [TAG_BITS-1:0]   w_max_tag;
    logic [AW-1:0]         w_max_idx;

    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free  = !r_m_valid || i_m_axis_tready;

    // slots past the table are ignored by load and read zeros
    assign w_in_range  = (32'(r_slot) < ENTRIES);
    assign w_slot_idx  = AW'(r_slot);

    assign w_rd_key    = w_rd_data[KW-1:0];
    assign w_rd_tag    = w_rd_data[MW-1:KW];

    // strictly smaller candidate replaces the current maximum
    assign w_take      = (r_key < w_max_key);

    assign w_scan_more = (r_cnt < CW'(ENTRIES));
    assign w_scan_last = r_pend && !w_scan_more;

    assign w_scan_ctl.valid = (r_state == S_SCAN) && r_pend;
    assign w_scan_ctl.first = (r_pend_idx == '0);

    // memory port steering
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_slot_idx;
        w_wr_data = {r_tag, r_key};
        w_rd_en   = 1'b0;
        w_rd_addr = r_cnt[AW-1:0];
        unique case (r_state)
            S_START: begin
                unique case (r_cmd)
                    tkr_pkg::CMD_LOAD: begin
                        w_wr_en = w_in_range;
                    end
                    tkr_pkg::CMD_READ: begin
                        w_rd_en   = w_in_range;
                        w_rd_addr = w_slot_idx;
                    end
                    tkr_pkg::CMD_OFFER: begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                    end
                    default: begin
                        w_rd_en = 1'b0;
                    end
                endcase
            end
            S_SCAN: begin
                w_rd_en = w_scan_more;
            end
            S_DECIDE: begin
                w_wr_en   = w_take;
                w_wr_addr = w_max_idx;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            // output valid: set when the final state hands over, cleared on take
            if ((r_state == S_DONE) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_cmd   <= tkr_pkg::t_cmd'(i_s_axis_tuser);
                        r_slot  <= i_s_axis_tdata[5:0];
                        r_key   <= i_s_axis_tdata[37:6];
                        r_tag   <= TAG_BITS'(i_s_axis_tdata[53:38]);
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    unique case (r_cmd)
                        tkr_pkg::CMD_LOAD: begin
                            if (w_in_range) begin
                                r_res_key  <= r_key;
                                r_res_tag  <= r_tag;
                                r_res_slot <= r_slot;
                                r_res_acc  <= 1'b1;
                            end else begin
                                r_res_key  <= '0;
                                r_res_tag  <= '0;
                                r_res_slot <= '0;
                                r_res_acc  <= 1'b0;
                            end
                            r_state <= S_DONE;
                        end
                        tkr_pkg::CMD_READ: begin
                            r_res_key <= '0;
                            r_res_tag <= '0;
                            r_res_acc <= 1'b0;
                            if (w_in_range) begin
                                r_res_slot <= r_slot;
                                r_state    <= S_RDWAIT;
                            end else begin
                                r_res_slot <= '0;
                                r_state    <= S_DONE;
                            end
                        end
                        tkr_pkg::CMD_OFFER: begin
                            r_cnt      <= CW'(1);
                            r_pend     <= 1'b1;
                            r_pend_idx <= '0;
                            r_state    <= S_SCAN;
                        end
                        default: begin
                            r_res_key  <= '0;
                            r_res_tag  <= '0;
                            r_res_slot <= '0;
                            r_res_acc  <= 1'b0;
                            r_state    <= S_DONE;
                        end
                    endcase
                end
                S_RDWAIT: begin
                    r_res_key <= w_rd_key;
                    r_res_tag <= w_rd_tag;
                    r_state   <= S_DONE;
                end
                S_SCAN: begin
                    r_pend     <= w_scan_more;
                    r_pend_idx <= r_cnt[AW-1:0];
                    if (w_scan_more) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    if (w_scan_last) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (w_take) begin
                        r_res_key  <= w_max_key;
                        r_res_tag  <= w_max_tag;
                        r_res_slot <= SW'(w_max_idx);   // modulo 64 on wide tables
                        r_res_acc  <= 1'b1;
                    end else begin
                        r_res_key  <= r_key;
                        r_res_tag  <= r_tag;
                        r_res_slot <= '0;
                        r_res_acc  <= 1'b0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_key  <= r_res_key;
                        r_out_tag  <= TW'(r_res_tag);
                        r_out_slot <= r_res_slot;
                        r_out_acc  <= r_res_acc;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    tkr_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (MW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    tkr_scan #(
        .AW       (AW),
        .TAG_BITS (TAG_BITS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_ctl     (w_scan_ctl),
        .i_idx     (r_pend_idx),
        .i_key     (w_rd_key),
        .i_tag     (w_rd_tag),
        .o_max_key (w_max_key),
        .o_max_tag (w_max_tag),
        .o_max_idx (w_max_idx)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_slot, r_out_tag, r_out_key};
    assign o_m_axis_tuser  = r_out_acc;

    // one transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> !o_s_axis_tready)
        else $error("input accepted while a transaction is in progress");

    // a result is only presented out of the final sequencer state
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == S_DONE))
        else $error("result presented outside the final state");

    // the decision only follows a complete scan of the table
    a_scan_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> (r_cnt == CW'(ENTRIES)) && !r_pend)
        else $error("offer decided before every entry was scanned");

endmodule

>>> hdl/tkr_mem.sv
// Entry store of the top-k filter: one write port, one read port with
// registered read data. Depends on nothing.
module tkr_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/tkr_scan.sv
// Running-maximum unit of the top-k filter: one signed comparator fed one
// entry per cycle. Depends on tkr_pkg.
module tkr_scan #(
    parameter int AW       = 6,
    parameter int TAG_BITS = 16
) (
    input  logic                             i_clk,
    input  tkr_pkg::t_scan_ctl               i_ctl,
    input  logic [AW-1:0]                    i_idx,
    input  logic signed [tkr_pkg::KEY_W-1:0] i_key,
    input  logic [TAG_BITS-1:0]              i_tag,
    output logic signed [tkr_pkg::KEY_W-1:0] o_max_key,
    output logic [TAG_BITS-1:0]              o_max_tag,
    output logic [AW-1:0]                    o_max_idx
);

    logic signed [tkr_pkg::KEY_W-1:0] r_max_key;
    logic [TAG_BITS-1:0]              r_max_tag;
    logic [AW-1:0]                    r_max_idx;

    // strictly greater keeps the lowest slot on ties
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid && (i_ctl.first || (i_key > r_max_key))) begin
            r_max_key <= i_key;
            r_max_tag <= i_tag;
            r_max_idx <= i_idx;
        end
    end

    assign o_max_key = r_max_key;
    assign o_max_tag = r_max_tag;
    assign o_max_idx = r_max_idx;

endmodule
